>>> rtl/pts_pkg.sv
// Shared types, widths and codes for the priority thread scheduler.
package pts_pkg;

    localparam int PTS_MAX_THREADS = 16;
    localparam int OP_W            = 2;
    localparam int TID_W           = 4;
    localparam int PRIO_W          = 8;
    localparam int ERR_W           = 16;
    localparam int TSTATE_W        = 3;

    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_QUEUE_EMPTY = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_SPAWN     = 2'd0,
        OP_SUSPEND   = 2'd1,
        OP_RESUME    = 2'd2,
        OP_TERMINATE = 2'd3
    } t_op;

    typedef enum logic [TSTATE_W-1:0] {
        ST_CURRENT    = 3'd0,
        ST_READY      = 3'd1,
        ST_SUSPENDED  = 3'd2,
        ST_RESUMED    = 3'd3,
        ST_TERMINATED = 3'd4
    } t_slot_state;

    typedef struct packed {
        t_slot_state              st;
        logic signed [PRIO_W-1:0] prio;
        logic signed [ERR_W-1:0]  err;
    } t_slot_word;

    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic signed [PRIO_W-1:0] prio;
    } t_q_cmd;

    typedef struct packed {
        logic busy;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_MOD,
        SQ_PUSH,
        SQ_POP,
        SQ_HWR,
        SQ_OREAD,
        SQ_LOAD
    } t_seq;

endpackage

>>> rtl/pts_if.sv
// Valid/ready channel interfaces for scheduler requests and results.
interface pts_in_if import pts_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [TID_W-1:0]         thread_id;
    logic signed [PRIO_W-1:0] priority_req;
    logic signed [ERR_W-1:0]  error_value;

    modport source (output valid, output operation, output thread_id,
                    output priority_req, output error_value, input ready);
    modport sink   (input valid, input operation, input thread_id,
                    input priority_req, input error_value, output ready);
endinterface

interface pts_out_if import pts_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [TID_W-1:0]        running_thread;
    logic signed [ERR_W-1:0] running_error;
    logic [TSTATE_W-1:0]     target_state;
    logic                    switched;
    logic                    status;

    modport source (output valid, output running_thread, output running_error,
                    output target_state, output switched, output status,
                    input ready);
    modport sink   (input valid, input running_thread, input running_error,
                    input target_state, input switched, input status,
                    output ready);
endinterface

>>> rtl/pts_slot_mem.sv
// Per-slot state, priority and error table: one read and one write port.
module pts_slot_mem import pts_pkg::*; #(
    parameter int MaxThreads = PTS_MAX_THREADS,
    parameter int SlotW      = $clog2(MaxThreads)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SlotW-1:0] i_rd_addr,
    output t_slot_word       o_rd_word,
    input  logic             i_we,
    input  logic [SlotW-1:0] i_wr_addr,
    input  t_slot_word       i_wr_word
);

    t_slot_word             mem [MaxThreads];
    logic [MaxThreads-1:0]  r_valid;
    t_slot_word             r_rd;
    logic                   r_rd_v;
    logic                   r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_word;
        end
        r_rd      <= mem[i_rd_addr];
        r_rd_zero <= (i_rd_addr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_v <= r_valid[i_rd_addr];
        end
    end

    // unwritten entries read as the reset contents
    always_comb begin
        if (r_rd_v) begin
            o_rd_word = r_rd;
        end else begin
            o_rd_word.st   = r_rd_zero ? ST_CURRENT : ST_TERMINATED;
            o_rd_word.prio = '0;
            o_rd_word.err  = '0;
        end
    end

endmodule

>>> rtl/pts_ready_queue.sv
// Priority-ordered ready queue: serial insert-point scan, then shift insert.
module pts_ready_queue import pts_pkg::*; #(
    parameter int MaxThreads = PTS_MAX_THREADS,
    parameter int SlotW      = $clog2(MaxThreads)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_cmd           i_cmd,
    input  logic [SlotW-1:0] i_slot,
    output t_q_stat          o_stat,
    output logic [SlotW-1:0] o_head
);

    localparam int CntW = $clog2(MaxThreads + 1);

    logic [SlotW-1:0]         r_qs [MaxThreads];
    logic signed [PRIO_W-1:0] r_qp [MaxThreads];
    logic [CntW-1:0]          r_cnt;
    logic                     r_scan;
    logic [CntW-1:0]          r_k;
    logic [SlotW-1:0]         r_ns;
    logic signed [PRIO_W-1:0] r_np;

    logic                     at_end;
    logic signed [PRIO_W-1:0] cur_p;
    logic                     hit;

    assign at_end = (r_k == r_cnt);
    assign cur_p  = r_qp[r_k[SlotW-1:0]];
    assign hit    = at_end || (cur_p > r_np);

    assign o_stat.busy  = r_scan;
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_qs[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_scan <= 1'b0;
            r_k    <= '0;
        end else if (r_scan) begin
            if (hit) begin
                r_scan <= 1'b0;
                if (r_cnt != CntW'(MaxThreads)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end else if (i_cmd.push) begin
            r_scan <= 1'b1;
            r_k    <= '0;
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_scan && i_cmd.push) begin
            r_ns <= i_slot;
            r_np <= i_cmd.prio;
        end
        for (int i = 0; i < MaxThreads; i++) begin
            if (r_scan) begin
                if (hit && r_cnt != CntW'(MaxThreads)) begin
                    if (CntW'(i) == r_k) begin
                        r_qs[i] <= r_ns;
                        r_qp[i] <= r_np;
                    end else if (CntW'(i) > r_k && i > 0) begin
                        r_qs[i] <= r_qs[(i > 0) ? i - 1 : 0];
                        r_qp[i] <= r_qp[(i > 0) ? i - 1 : 0];
                    end
                end
            end else if (!i_cmd.push && i_cmd.pop && i < MaxThreads - 1) begin
                r_qs[i] <= r_qs[(i < MaxThreads - 1) ? i + 1 : i];
                r_qp[i] <= r_qp[(i < MaxThreads - 1) ? i + 1 : i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MaxThreads)
        else $error("ready queue count above capacity");
    a_pop_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (!r_scan && r_cnt != '0))
        else $error("pop while scanning or empty");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan |-> (r_k <= r_cnt))
        else $error("scan index past queue end");
`endif

endmodule

>>> rtl/priority_thread_scheduler_unit.sv
// Thread scheduler over slot table and ready queue. A request reads its slot, writes
// the updated entry and, when the slot is queued, waits while the ready queue scans
// serially for the insert point; suspend and terminate then pop the queue head and
// write it back as current, or keep the running slot when the queue is empty. A spawn
// or resume with a thread_id at or above MAX_THREADS skips the slot update. The slot
// table has a single read port. A finished result sits in an
// output register, and the next request is taken while it waits; the following
// result holds in its load state until that register is free.
module priority_thread_scheduler_unit import pts_pkg::*; #(
    parameter int MAX_THREADS = PTS_MAX_THREADS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pts_in_if.sink   i_in,
    pts_out_if.source o_out
);

    localparam int SlotW = $clog2(MAX_THREADS);

    t_seq                     r_state, n_state;
    t_op                      r_op;
    logic signed [PRIO_W-1:0] r_prio;
    logic signed [ERR_W-1:0]  r_err;
    logic [SlotW-1:0]         r_a;
    logic [SlotW-1:0]         r_run;
    logic [SlotW-1:0]         r_h;
    t_slot_word               r_word;
    t_slot_state              r_tstate;
    logic                     r_sw;
    logic                     r_empty;

    logic                     r_ovalid;
    logic [TID_W-1:0]         r_o_run;
    logic signed [ERR_W-1:0]  r_o_err;
    logic [TSTATE_W-1:0]      r_o_tstate;
    logic                     r_o_sw;
    logic                     r_o_status;

    logic [SlotW-1:0]         rd_addr;
    t_slot_word               rd_word;
    logic                     we;
    logic [SlotW-1:0]         wr_addr;
    t_slot_word               wr_word;
    t_q_cmd                   q_cmd;
    t_q_stat                  q_stat;
    logic [SlotW-1:0]         q_head;

    logic                     accept;
    logic                     tid_ok;
    logic                     is_switch;
    logic                     load_ok;
    t_slot_word               m_word;
    logic                     m_push;
    logic signed [PRIO_W-1:0] m_prio;

    assign accept    = i_in.valid && i_in.ready;
    assign tid_ok    = 32'(i_in.thread_id) < MAX_THREADS;
    assign is_switch = (r_op == OP_SUSPEND) || (r_op == OP_TERMINATE);
    assign load_ok   = !r_ovalid || o_out.ready;

    pts_slot_mem #(.MaxThreads(MAX_THREADS), .SlotW(SlotW)) u_slot_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_addr(rd_addr),
        .o_rd_word(rd_word),
        .i_we     (we),
        .i_wr_addr(wr_addr),
        .i_wr_word(wr_word)
    );

    pts_ready_queue #(.MaxThreads(MAX_THREADS), .SlotW(SlotW)) u_ready_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (q_cmd),
        .i_slot (r_a),
        .o_stat (q_stat),
        .o_head (q_head)
    );

    // slot update for the addressed slot
    always_comb begin
        m_word = rd_word;
        m_push = 1'b0;
        m_prio = rd_word.prio;
        case (r_op)
            OP_SPAWN: begin
                if (rd_word.st == ST_TERMINATED) begin
                    m_word.st   = ST_READY;
                    m_word.prio = r_prio;
                    m_word.err  = '0;
                    m_push      = 1'b1;
                    m_prio      = r_prio;
                end
            end
            OP_RESUME: begin
                m_word.err = r_err;
                if (rd_word.st == ST_SUSPENDED) begin
                    m_word.st = ST_READY;
                    m_push    = 1'b1;
                end else if (rd_word.st != ST_TERMINATED) begin
                    m_word.st = ST_RESUMED;
                end
            end
            OP_SUSPEND: begin
                if (rd_word.st == ST_RESUMED) begin
                    m_word.st = ST_READY;
                    m_push    = 1'b1;
                end else begin
                    m_word.st = ST_SUSPENDED;
                end
            end
            OP_TERMINATE: begin
                m_word.st = ST_TERMINATED;
            end
            default: begin
                m_word = rd_word;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE: begin
                if (accept) begin
                    if ((i_in.operation == OP_SPAWN || i_in.operation == OP_RESUME)
                        && !tid_ok) begin
                        n_state = SQ_OREAD;
                    end else begin
                        n_state = SQ_MOD;
                    end
                end
            end
            SQ_MOD: begin
                if (m_push) begin
                    n_state = SQ_PUSH;
                end else if (is_switch) begin
                    n_state = SQ_POP;
                end else begin
                    n_state = SQ_OREAD;
                end
            end
            SQ_PUSH: begin
                if (!q_stat.busy) begin
                    n_state = is_switch ? SQ_POP : SQ_OREAD;
                end
            end
            SQ_POP: begin
                n_state = q_stat.empty ? SQ_OREAD : SQ_HWR;
            end
            SQ_HWR:   n_state = SQ_OREAD;
            SQ_OREAD: n_state = SQ_LOAD;
            SQ_LOAD: begin
                if (load_ok) begin
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        rd_addr    = r_run;
        we         = 1'b0;
        wr_addr    = r_a;
        wr_word    = m_word;
        q_cmd.push = 1'b0;
        q_cmd.pop  = 1'b0;
        q_cmd.prio = m_prio;
        case (r_state)
            SQ_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.operation == OP_SPAWN || i_in.operation == OP_RESUME) begin
                    rd_addr = SlotW'(i_in.thread_id);
                end
            end
            SQ_MOD: begin
                we         = 1'b1;
                q_cmd.push = m_push;
            end
            SQ_POP: begin
                if (q_stat.empty) begin
                    we         = 1'b1;
                    wr_addr    = r_run;
                    wr_word    = r_word;
                    wr_word.st = ST_CURRENT;
                end else begin
                    q_cmd.pop = 1'b1;
                    rd_addr   = q_head;
                end
            end
            SQ_HWR: begin
                we         = 1'b1;
                wr_addr    = r_h;
                wr_word    = rd_word;
                wr_word.st = ST_CURRENT;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SQ_IDLE;
            r_run    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == SQ_HWR) begin
                r_run <= r_h;
            end
            if (r_state == SQ_LOAD && load_ok) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SQ_IDLE: begin
                if (accept) begin
                    r_op     <= t_op'(i_in.operation);
                    r_prio   <= i_in.priority_req;
                    r_err    <= i_in.error_value;
                    r_sw     <= 1'b0;
                    r_empty  <= 1'b0;
                    r_tstate <= ST_TERMINATED;
                    if (i_in.operation == OP_SPAWN || i_in.operation == OP_RESUME) begin
                        r_a <= SlotW'(i_in.thread_id);
                    end else begin
                        r_a <= r_run;
                    end
                end
            end
            SQ_MOD: begin
                r_word   <= m_word;
                r_tstate <= m_word.st;
            end
            SQ_POP: begin
                if (q_stat.empty) begin
                    r_empty  <= 1'b1;
                    r_tstate <= ST_CURRENT;
                end else begin
                    r_h      <= q_head;
                    r_tstate <= (q_head == r_run) ? ST_CURRENT : r_word.st;
                end
            end
            SQ_HWR: begin
                r_sw <= (r_h != r_run);
            end
            SQ_LOAD: begin
                if (load_ok) begin
                    r_o_run    <= TID_W'(r_run);
                    r_o_err    <= rd_word.err;
                    r_o_tstate <= r_tstate;
                    r_o_sw     <= r_sw;
                    r_o_status <= r_empty ? STATUS_QUEUE_EMPTY : STATUS_OK;
                end
            end
            default: begin
                r_h <= r_h;
            end
        endcase
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.running_thread = r_o_run;
    assign o_out.running_error  = r_o_err;
    assign o_out.target_state   = r_o_tstate;
    assign o_out.switched       = r_o_sw;
    assign o_out.status         = r_o_status;

`ifndef NO_ASSERTIONS
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_run) < MAX_THREADS)
        else $error("running slot out of range");
    a_switch_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.switched) |-> (o_out.status == STATUS_OK))
        else $error("switch reported with empty queue");
    a_idle_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !q_stat.busy)
        else $error("request taken while queue insert in progress");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the priority thread scheduler, with its own schedule prediction.
module testbench import pts_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [TID_W-1:0]        running_thread;
        logic signed [ERR_W-1:0] running_error;
        t_slot_state             target_state;
        logic                    switched;
        logic                    status;
    } t_sched_result;

    logic i_clk;
    logic i_rst_n;

    pts_in_if  req_if ();
    pts_out_if res_if ();

    priority_thread_scheduler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    t_slot_state              slot_st   [PTS_MAX_THREADS];
    logic signed [PRIO_W-1:0] slot_prio [PTS_MAX_THREADS];
    logic signed [ERR_W-1:0]  slot_err  [PTS_MAX_THREADS];
    logic [TID_W-1:0]         ready_order[$];
    logic [TID_W-1:0]         running_slot;

    t_sched_result pending_results[$];
    int            op_count[4];
    int            results_checked;
    int            switches_seen;
    int            empty_switches;
    int            mismatches;
    int            res_hold;
    bit            no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Timeout waiting for scheduler results");
        $display("Mismatches found");
        $finish;
    end

    function automatic void ready_insert(logic [TID_W-1:0] slot);
        int pos;
        pos = 0;
        while (pos < ready_order.size() && slot_prio[ready_order[pos]] <= slot_prio[slot])
            pos++;
        ready_order.insert(pos, slot);
    endfunction

    function automatic t_sched_result schedule_step(t_op op, logic [TID_W-1:0] tid,
                                                    logic signed [PRIO_W-1:0] prio,
                                                    logic signed [ERR_W-1:0] err);
        t_sched_result    r;
        logic [TID_W-1:0] prev;
        logic [TID_W-1:0] head;
        t_slot_state      tstate;
        r.switched = 1'b0;
        r.status   = STATUS_OK;
        case (op)
            OP_SPAWN, OP_RESUME: begin
                if (op == OP_SPAWN) begin
                    if (slot_st[tid] == ST_TERMINATED) begin
                        slot_prio[tid] = prio;
                        slot_err[tid]  = '0;
                        slot_st[tid]   = ST_READY;
                        ready_insert(tid);
                    end
                end else begin
                    slot_err[tid] = err;
                    if (slot_st[tid] == ST_SUSPENDED) begin
                        slot_st[tid] = ST_READY;
                        ready_insert(tid);
                    end else if (slot_st[tid] != ST_TERMINATED) begin
                        slot_st[tid] = ST_RESUMED;
                    end
                end
                tstate = slot_st[tid];
            end
            default: begin
                prev = running_slot;
                if (op == OP_SUSPEND) begin
                    if (slot_st[prev] == ST_RESUMED) begin
                        slot_st[prev] = ST_READY;
                        ready_insert(prev);
                    end else begin
                        slot_st[prev] = ST_SUSPENDED;
                    end
                end else begin
                    slot_st[prev] = ST_TERMINATED;
                end
                if (ready_order.size() == 0) begin
                    slot_st[running_slot] = ST_CURRENT;
                    r.status = STATUS_QUEUE_EMPTY;
                end else begin
                    head = ready_order.pop_front();
                    slot_st[head] = ST_CURRENT;
                    if (head != running_slot) begin
                        running_slot = head;
                        r.switched = 1'b1;
                    end
                end
                tstate = slot_st[prev];
            end
        endcase
        r.running_thread = running_slot;
        r.running_error  = slot_err[running_slot];
        r.target_state   = tstate;
        return r;
    endfunction

    task automatic send_request(t_op op, logic [TID_W-1:0] tid,
                                logic signed [PRIO_W-1:0] prio,
                                logic signed [ERR_W-1:0] err);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        = 1'b1;
        req_if.operation    = op;
        req_if.thread_id    = tid;
        req_if.priority_req = prio;
        req_if.error_value  = err;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_results.push_back(schedule_step(op, tid, prio, err));
        op_count[op]++;
        @(negedge i_clk);
    endtask

    // Result side: per-transfer stall drawn after each accepted result
    always @(negedge i_clk) begin
        if (res_hold > 0) begin
            res_if.ready = 1'b0;
            res_hold--;
        end else begin
            res_if.ready = 1'b1;
        end
    end

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("running_thread", 32'(want.running_thread),
                            32'(res_if.running_thread));
                check_field("running_error", 32'(want.running_error),
                            32'(res_if.running_error));
                check_field("target_state", 32'(want.target_state),
                            32'(res_if.target_state));
                check_field("switched", 32'(want.switched), 32'(res_if.switched));
                check_field("status", 32'(want.status), 32'(res_if.status));
                results_checked++;
                if (want.switched) switches_seen++;
                if (want.status == STATUS_QUEUE_EMPTY) empty_switches++;
            end
            res_hold = no_idle ? 0 : $urandom_range(0, 16);
        end
    end

    task automatic test_empty_queue_switch();
        send_request(OP_SUSPEND, 4'd0, 8'sd0, 16'sd0);
        send_request(OP_TERMINATE, 4'd0, 8'sd0, 16'sd0);
    endtask

    task automatic test_spawn_order();
        send_request(OP_SPAWN, 4'd1, 8'sd127, 16'sd0);
        send_request(OP_SPAWN, 4'd2, -8'sd128, 16'sd0);
        send_request(OP_SPAWN, 4'd3, 8'sd0, 16'sd0);
        send_request(OP_SPAWN, 4'd4, 8'sd0, -16'sd1);
        send_request(OP_SPAWN, 4'd2, 8'sd5, 16'sd0);
        send_request(OP_SPAWN, 4'd0, 8'sd5, 16'sd0);
    endtask

    task automatic test_resume_cases();
        send_request(OP_RESUME, 4'd5, 8'sd0, -16'sd32768);
        send_request(OP_SPAWN, 4'd5, 8'sd0, 16'sd0);
        send_request(OP_RESUME, 4'd1, 8'sd0, 16'sd32767);
        send_request(OP_SUSPEND, 4'd0, 8'sd0, 16'sd0);
        send_request(OP_RESUME, 4'd0, 8'sd0, 16'sh1234);
        send_request(OP_RESUME, 4'd2, 8'sd0, -16'sd1);
        send_request(OP_SUSPEND, 4'd0, 8'sd0, 16'sd0);
    endtask

    task automatic test_switch_order();
        repeat (6) send_request(OP_TERMINATE, 4'd0, 8'sd0, 16'sd0);
        send_request(OP_SPAWN, 4'd15, -8'sd1, 16'sd0);
        send_request(OP_RESUME, 4'd15, 8'sd0, 16'sh5555);
        send_request(OP_TERMINATE, 4'd8, 8'sd0, 16'sh2aaa);
    endtask

    task automatic test_random_traffic(int count);
        int                       pick;
        int                       n;
        logic [TID_W-1:0]         tid;
        logic [TID_W-1:0]         cand[$];
        logic signed [PRIO_W-1:0] prio;
        t_slot_state              wanted;
        t_op                      op;
        for (n = 0; n < count; n++) begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            op = (pick < 35) ? OP_SPAWN : (pick < 55) ? OP_SUSPEND :
                 (pick < 80) ? OP_RESUME : OP_TERMINATE;
            tid = TID_W'($urandom_range(0, 15));
            wanted = (op == OP_SPAWN) ? ST_TERMINATED : ST_SUSPENDED;
            if ((op == OP_SPAWN || op == OP_RESUME) && $urandom_range(0, 9) < 7) begin
                cand.delete();
                for (int s = 0; s < PTS_MAX_THREADS; s++)
                    if (slot_st[s] == wanted) cand.push_back(TID_W'(s));
                if (cand.size() > 0) tid = cand[$urandom_range(0, cand.size() - 1)];
            end
            prio = $urandom_range(0, 1) ? $signed(8'($urandom_range(0, 4)) - 8'd2)
                                        : $signed(8'($urandom));
            send_request(op, tid, prio, $signed(16'($urandom)));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.operation    = OP_SPAWN;
        req_if.thread_id    = '0;
        req_if.priority_req = '0;
        req_if.error_value  = '0;
        res_if.ready        = 1'b0;
        res_hold            = 0;
        no_idle             = 1'b0;
        mismatches          = 0;
        results_checked     = 0;
        switches_seen       = 0;
        empty_switches      = 0;
        for (int s = 0; s < 4; s++) op_count[s] = 0;
        for (int s = 0; s < PTS_MAX_THREADS; s++) begin
            slot_st[s]   = (s == 0) ? ST_CURRENT : ST_TERMINATED;
            slot_prio[s] = '0;
            slot_err[s]  = '0;
        end
        running_slot = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue_switch();
        test_spawn_order();
        test_resume_cases();
        test_switch_order();
        test_random_traffic(1000);

        req_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests: %0d spawn, %0d suspend, %0d resume, %0d terminate.",
                 op_count[OP_SPAWN] + op_count[OP_SUSPEND] + op_count[OP_RESUME] +
                 op_count[OP_TERMINATE], op_count[OP_SPAWN], op_count[OP_SUSPEND],
                 op_count[OP_RESUME], op_count[OP_TERMINATE]);
        $display("Checked %0d results, %0d thread switches, %0d switches on an empty queue.",
                 results_checked, switches_seen, empty_switches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
